@@ rtl/bba_pkg.sv @@
package bba_pkg;

  localparam int LEVELS = 14;
  localparam int MIN_BLOCK_LOG2 = 3;
  localparam int LVL_W = $clog2(LEVELS + 1);
  localparam int GRAN_W = LEVELS - 1;
  localparam int GRANULES = 1 << GRAN_W;
  localparam int MAP_BITS = (1 << LEVELS) - 1;
  localparam int MAP_W = LEVELS;
  localparam int WORD_W = 64;
  localparam int WORD_LOG2 = 6;
  localparam int HDR_W = 5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_DOUBLE_FREE = 2'd2;
  localparam logic [1:0] ST_BAD = 2'd3;

  // datapath commands
  typedef struct packed {
    logic load;
    logic lvl_set;
    logic [LVL_W-1:0] lvl;
    logic scan_rd;
    logic scan_adv;
    logic map_rd;
    logic map_wr;
    logic map_val;
    logic map_buddy;
    logic take_pick;
    logic lvl_down;
    logic lvl_up;
    logic merge;
    logic hdr_rd;
    logic hdr_wr;
    logic hdr_clr;
    logic clr_step;
  } bba_cmd_t;

  typedef struct packed {
    logic mode;
    logic [15:0] req;
    logic [15:0] pay;
    logic fits;
    logic fits_lower;
    logic scan_hit;
    logic scan_end;
    logic map_bit;
    logic top;
    logic lvl_zero;
    logic addr_bad;
    logic hdr_zero;
    logic hdr_bad;
    logic clr_done;
  } bba_sts_t;

  function automatic logic [MAP_W-1:0] map_index(input logic [LVL_W-1:0] lvl,
                                                 input logic [GRAN_W-1:0] g);
    logic [MAP_W:0] base;
    logic [GRAN_W-1:0] sh;
    base = (({{MAP_W{1'b0}}, 1'b1} << LEVELS) -
            ({{MAP_W{1'b0}}, 1'b1} << (LEVELS - 32'(lvl))));
    sh = g >> lvl;
    return MAP_W'(base + (MAP_W+1)'(sh));
  endfunction

endpackage

@@ rtl/bba_ctrl.sv @@
module bba_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] st_code,
  output bba_pkg::bba_cmd_t cmd,
  input  bba_pkg::bba_sts_t sts
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ALVL   = 4'd2;
  localparam logic [3:0] S_ASCAN  = 4'd3;
  localparam logic [3:0] S_ACHK   = 4'd4;
  localparam logic [3:0] S_ASPLIT = 4'd5;
  localparam logic [3:0] S_AHDR   = 4'd6;
  localparam logic [3:0] S_FHRD   = 4'd7;
  localparam logic [3:0] S_FHCHK  = 4'd8;
  localparam logic [3:0] S_FBRD   = 4'd9;
  localparam logic [3:0] S_FBCHK  = 4'd10;
  localparam logic [3:0] S_FSET   = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;
  localparam logic [3:0] S_ASCAN2 = 4'd13;

  logic [3:0] state, state_next;
  logic [1:0] st_next;
  logic [bba_pkg::LVL_W-1:0] lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      st_code <= bba_pkg::ST_OK;
      lvl <= '0;
    end else begin
      state <= state_next;
      st_code <= st_next;
      if (cmd.lvl_set) lvl <= cmd.lvl;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    st_next = st_code;
    cmd = '0;
    cmd.lvl = lvl;
    unique case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.lvl_set = 1'b1;
          cmd.lvl = '0;
          st_next = bba_pkg::ST_OK;
          state_next = S_ALVL;
        end
      end
      S_ALVL: begin
        if (sts.mode) begin
          if (sts.addr_bad) begin
            st_next = bba_pkg::ST_BAD;
            state_next = S_OUT;
          end else begin
            cmd.hdr_rd = 1'b1;
            state_next = S_FHRD;
          end
        end else if (lvl == bba_pkg::LVL_W'(bba_pkg::LEVELS)) begin
          st_next = bba_pkg::ST_NO_SPACE;
          state_next = S_OUT;
        end else if (!sts.fits) begin
          cmd.lvl_set = 1'b1;
          cmd.lvl = lvl + 1'b1;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next = S_ASCAN;
        end
      end
      S_ASCAN: state_next = S_ASCAN2;
      S_ASCAN2: begin
        if (sts.scan_hit) begin
          cmd.take_pick = 1'b1;
          state_next = S_ACHK;
        end else if (sts.scan_end) begin
          cmd.lvl_set = 1'b1;
          cmd.lvl = lvl + 1'b1;
          state_next = S_ALVL;
        end else begin
          cmd.scan_adv = 1'b1;
          cmd.scan_rd = 1'b1;
          state_next = S_ASCAN;
        end
      end
      S_ACHK: begin
        cmd.map_wr = 1'b1;
        cmd.map_val = 1'b0;
        state_next = S_ASPLIT;
      end
      S_ASPLIT: begin
        if (!sts.lvl_zero && sts.fits_lower) begin
          cmd.lvl_set = 1'b1;
          cmd.lvl = lvl - 1'b1;
          cmd.lvl_down = 1'b1;
          cmd.map_wr = 1'b1;
          cmd.map_val = 1'b1;
          cmd.map_buddy = 1'b1;
        end else begin
          state_next = S_AHDR;
        end
      end
      S_AHDR: begin
        cmd.hdr_wr = 1'b1;
        state_next = S_OUT;
      end
      S_FHRD: state_next = S_FHCHK;
      S_FHCHK: begin
        if (sts.hdr_zero) begin
          st_next = bba_pkg::ST_DOUBLE_FREE;
          state_next = S_OUT;
        end else if (sts.hdr_bad) begin
          st_next = bba_pkg::ST_BAD;
          state_next = S_OUT;
        end else begin
          cmd.hdr_clr = 1'b1;
          state_next = S_FBRD;
        end
      end
      S_FBRD: begin
        if (sts.top) begin
          state_next = S_FSET;
        end else begin
          cmd.map_rd = 1'b1;
          cmd.map_buddy = 1'b1;
          state_next = S_FBCHK;
        end
      end
      S_FBCHK: begin
        if (sts.map_bit) begin
          cmd.map_wr = 1'b1;
          cmd.map_val = 1'b0;
          cmd.map_buddy = 1'b1;
          cmd.merge = 1'b1;
          cmd.lvl_up = 1'b1;
          state_next = S_FBRD;
        end else begin
          state_next = S_FSET;
        end
      end
      S_FSET: begin
        cmd.map_wr = 1'b1;
        cmd.map_val = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/bba_datapath.sv @@
module bba_datapath (
  input  logic clk,
  input  logic rst,
  input  logic [0:0] in_mode,
  input  logic [15:0] in_req,
  input  logic [15:0] in_pay,
  input  bba_pkg::bba_cmd_t cmd,
  output bba_pkg::bba_sts_t sts,
  output logic [15:0] result_offset
);

  localparam int NWORDS = (bba_pkg::MAP_BITS + bba_pkg::WORD_W) / bba_pkg::WORD_W;
  localparam int WA_W = bba_pkg::MAP_W - bba_pkg::WORD_LOG2;
  // map bit of the whole-arena block
  localparam int TOP_IDX = (1 << bba_pkg::LEVELS) - 2;
  localparam int TOP_WA = TOP_IDX >> bba_pkg::WORD_LOG2;
  localparam int TOP_BIT = TOP_IDX & (bba_pkg::WORD_W - 1);

  // free map as 64-bit words; header store per granule
  logic [bba_pkg::WORD_W-1:0] map_mem [NWORDS];
  logic [bba_pkg::HDR_W-1:0] hdr_mem [bba_pkg::GRANULES];

  logic mode;
  logic [15:0] req, pay;
  logic [bba_pkg::LVL_W-1:0] lvl;
  logic [bba_pkg::GRAN_W-1:0] g, scan_g;
  logic [bba_pkg::WORD_W-1:0] rd_word;
  logic [bba_pkg::WORD_LOG2-1:0] rd_bit;
  logic [bba_pkg::HDR_W-1:0] hdr_q;
  logic [bba_pkg::GRAN_W:0] clr_cnt;
  logic [bba_pkg::GRAN_W:0] scan_n;
  logic done_clr;

  // map bit indices for access, scan, buddy, next scan word and split buddy
  logic [bba_pkg::MAP_W-1:0] acc_idx, scan_idx, buddy_idx, scan_nidx, split_idx;
  logic [bba_pkg::GRAN_W-1:0] buddy_g;
  logic [bba_pkg::GRAN_W:0] lvl_cnt;
  logic [bba_pkg::WORD_W-1:0] live;
  logic [bba_pkg::WORD_LOG2:0] pick;
  logic [bba_pkg::WORD_LOG2-1:0] scan_off;
  logic [bba_pkg::GRAN_W:0] scan_step;
  logic [bba_pkg::GRAN_W:0] remain;
  logic [bba_pkg::GRAN_W:0] hit_n;
  logic [16:0] start;
  logic [16:0] usable, usable_lo;

  assign buddy_g = g ^ (bba_pkg::GRAN_W'(1) << lvl);
  assign buddy_idx = bba_pkg::map_index(lvl, buddy_g);
  assign acc_idx = cmd.map_buddy ? buddy_idx : bba_pkg::map_index(lvl, g);
  assign scan_idx = bba_pkg::map_index(lvl, scan_g);
  assign lvl_cnt = (bba_pkg::GRAN_W+1)'(bba_pkg::GRANULES) >> lvl;
  assign remain = lvl_cnt - scan_n;
  assign scan_off = scan_idx[bba_pkg::WORD_LOG2-1:0];
  assign scan_step = (bba_pkg::GRAN_W+1)'(bba_pkg::WORD_W - 32'(scan_off));
  assign scan_nidx = bba_pkg::map_index(lvl, scan_g + bba_pkg::GRAN_W'(scan_step << lvl));
  assign split_idx = bba_pkg::map_index(cmd.lvl, g ^ (bba_pkg::GRAN_W'(1) << cmd.lvl));

  always_comb begin
    live = rd_word >> rd_bit;
    for (int i = 0; i < bba_pkg::WORD_W; i++)
      if ((bba_pkg::GRAN_W+1)'(i) >= remain) live[i] = 1'b0;
    pick = 7'(bba_pkg::WORD_W);
    for (int i = bba_pkg::WORD_W - 1; i >= 0; i--)
      if (live[i]) pick = 7'(i);
  end
  assign hit_n = scan_n + (bba_pkg::GRAN_W+1)'(pick);

  assign usable = (17'd1 << (32'(lvl) + bba_pkg::MIN_BLOCK_LOG2)) - 17'd1;
  assign usable_lo = (lvl == '0) ? 17'd0
                   : (17'd1 << (32'(lvl) - 1 + bba_pkg::MIN_BLOCK_LOG2)) - 17'd1;
  assign start = {1'b0, pay} - 17'd1;

  // clearing pass: one header per cycle over all granules, map words while the
  // count is below NWORDS
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      done_clr <= 1'b0;
    end else if (cmd.clr_step && !done_clr) begin
      if (clr_cnt < (bba_pkg::GRAN_W+1)'(NWORDS))
        map_mem[clr_cnt[WA_W-1:0]] <= (clr_cnt[WA_W-1:0] == WA_W'(TOP_WA))
                                      ? (bba_pkg::WORD_W'(1) << TOP_BIT) : '0;
      hdr_mem[clr_cnt[bba_pkg::GRAN_W-1:0]] <= '0;
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (bba_pkg::GRAN_W+1)'(bba_pkg::GRANULES - 1)) done_clr <= 1'b1;
    end
    if (cmd.load) begin
      mode <= in_mode;
      req <= in_req;
      pay <= in_pay;
      result_offset <= '0;
      g <= bba_pkg::GRAN_W'(({1'b0, in_pay} - 17'd1) >> bba_pkg::MIN_BLOCK_LOG2);
      scan_g <= '0;
      scan_n <= '0;
    end
    if (cmd.lvl_set) lvl <= cmd.lvl;
    if (cmd.lvl_set && !cmd.load) begin
      scan_g <= '0;
      scan_n <= '0;
    end
    if (cmd.scan_rd) begin
      rd_word <= map_mem[cmd.scan_adv ? scan_nidx[bba_pkg::MAP_W-1:bba_pkg::WORD_LOG2]
                                      : scan_idx[bba_pkg::MAP_W-1:bba_pkg::WORD_LOG2]];
      rd_bit <= cmd.scan_adv ? '0 : scan_off;
    end
    if (cmd.scan_adv) begin
      scan_n <= scan_n + scan_step;
      scan_g <= scan_g + bba_pkg::GRAN_W'(scan_step << lvl);
    end
    if (cmd.take_pick) g <= bba_pkg::GRAN_W'(hit_n << lvl);
    if (cmd.map_rd) begin
      rd_word <= map_mem[acc_idx[bba_pkg::MAP_W-1:bba_pkg::WORD_LOG2]];
      rd_bit <= acc_idx[bba_pkg::WORD_LOG2-1:0];
    end
    if (cmd.map_wr) begin
      if (cmd.lvl_down)
        map_mem[split_idx[bba_pkg::MAP_W-1:bba_pkg::WORD_LOG2]]
          [split_idx[bba_pkg::WORD_LOG2-1:0]] <= cmd.map_val;
      else
        map_mem[acc_idx[bba_pkg::MAP_W-1:bba_pkg::WORD_LOG2]]
          [acc_idx[bba_pkg::WORD_LOG2-1:0]] <= cmd.map_val;
    end
    if (cmd.merge) begin
      if (buddy_g < g) g <= buddy_g;
    end
    if (cmd.lvl_up) lvl <= lvl + 1'b1;
    if (cmd.hdr_rd) hdr_q <= hdr_mem[g];
    if (cmd.hdr_clr) begin
      hdr_mem[g] <= '0;
      lvl <= bba_pkg::LVL_W'(hdr_q - 1'b1);
    end
    if (cmd.hdr_wr) begin
      hdr_mem[g] <= bba_pkg::HDR_W'(lvl) + 1'b1;
      result_offset <= 16'((17'(g) << bba_pkg::MIN_BLOCK_LOG2) + 17'd1);
    end
  end

  always_comb begin
    sts = '0;
    sts.mode = mode;
    sts.req = req;
    sts.pay = pay;
    sts.fits = (usable >= {1'b0, req});
    sts.fits_lower = (usable_lo >= {1'b0, req});
    sts.scan_hit = (pick != 7'(bba_pkg::WORD_W));
    sts.scan_end = (remain <= (bba_pkg::GRAN_W+1)'(bba_pkg::WORD_W - 32'(rd_bit)));
    sts.map_bit = rd_word[rd_bit];
    sts.top = (lvl == bba_pkg::LVL_W'(bba_pkg::LEVELS - 1));
    sts.lvl_zero = (lvl == '0);
    sts.addr_bad = (pay == 16'd0) ||
                   (start[bba_pkg::MIN_BLOCK_LOG2-1:0] != '0) ||
                   ((start >> bba_pkg::MIN_BLOCK_LOG2) >= 17'(bba_pkg::GRANULES));
    sts.hdr_zero = (hdr_q == '0);
    sts.hdr_bad = ((32'(hdr_q) - 1) >= bba_pkg::LEVELS);
    sts.clr_done = done_clr;
  end

endmodule

@@ rtl/buddy_block_allocator_top.sv @@
// Channel  | Dir | tuser             | tdata
// s_axis   | in  | [0]=mode          | [15:0]=request_bytes, [31:16]=payload_offset
// m_axis   | out | [1:0]=status      | [15:0]=result_offset
//
// One transaction in, one result out. Allocate: steps up past levels too small,
// scans the 64-bit map words of each level, moves up a level after an empty
// scan, splits while the lower level fits. Free: checks the header, merges
// with free buddies; a bad address or a zero or bad header ends early.
// After reset a clearing pass over all granules runs before s_axis_tready rises.
// One output register: a waiting result holds back the next result, not input.
module buddy_block_allocator_top (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [0:0] s_axis_tuser,   // mode
  input  logic [31:0] s_axis_tdata,  // request_bytes, payload_offset
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [1:0] m_axis_tuser,   // status
  output logic [15:0] m_axis_tdata   // result_offset
);

  bba_pkg::bba_cmd_t cmd;
  bba_pkg::bba_sts_t sts;
  logic [1:0] st_code;
  logic [15:0] res_off;
  logic res_valid, res_ready;
  logic out_full;
  logic [15:0] out_off;
  logic [1:0] out_st;

  bba_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(res_valid), .out_ready(res_ready),
    .st_code, .cmd, .sts
  );

  bba_datapath u_dp (
    .clk, .rst,
    .in_mode(s_axis_tuser),
    .in_req(s_axis_tdata[15:0]),
    .in_pay(s_axis_tdata[31:16]),
    .cmd, .sts,
    .result_offset(res_off)
  );

  // output register; offset forced to zero on any failure
  assign res_ready = !out_full || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_full <= 1'b1;
      out_off <= (st_code == bba_pkg::ST_OK) ? res_off : 16'd0;
      out_st <= st_code;
    end else if (m_axis_tready) begin
      out_full <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata = out_off;
  assign m_axis_tuser = out_st;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
    (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != bba_pkg::ST_OK) |->
    m_axis_tdata == 16'd0) else $error("offset on failure");

endmodule
